// ===== rtl/text_glyph_quad_generator_defines.svh =====
// ---------------------------------------------------------------------------
// text glyph quad generator assertion macros
// concurrent checks on clk, disabled while rst is high
// ---------------------------------------------------------------------------
`ifndef TEXT_GLYPH_QUAD_GENERATOR_DEFINES_SVH
`define TEXT_GLYPH_QUAD_GENERATOR_DEFINES_SVH

`ifndef SYNTH

// condition holds at every edge out of reset
`define TGQG_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tgqg check failed");

// antecedent implies consequent in the next cycle
`define TGQG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tgqg check failed");

`else

`define TGQG_ASSERT(label, cond)
`define TGQG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/tgqg_pkg.sv =====
// ---------------------------------------------------------------------------
// tgqg_pkg
// shared codes, constants and the controller command type
// ---------------------------------------------------------------------------
package tgqg_pkg;

  // action codes
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_CHAR  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_ASCII_OFFSET  = 3'd0;
  localparam logic [2:0] REG_CELL_WIDTH    = 3'd1;
  localparam logic [2:0] REG_GLYPH_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_GLYPH_COUNT   = 3'd3;
  localparam logic [2:0] REG_SURFACE_SHIFT = 3'd4;
  localparam logic [2:0] REG_ATLAS_COLUMNS = 3'd5;

  localparam logic [15:0] NEWLINE_CODE = 16'd10;

  // vertex order: tl, tr, bl, br, bl, tr
  localparam logic [2:0] LAST_VTX   = 3'd5;
  localparam logic [5:0] VTX_RIGHT  = 6'b101010;
  localparam logic [5:0] VTX_BOTTOM = 6'b011100;

  typedef struct packed {
    logic       accept;
    logic       div_init;
    logic       div_step;
    logic       mul;
    logic       sum;
    logic       emit;
    logic [2:0] vtx;
  } cmd_t;

endpackage

// ===== rtl/text_glyph_quad_generator.sv =====
// ---------------------------------------------------------------------------
// text_glyph_quad_generator
// text stream to six textured vertices per character
// ---------------------------------------------------------------------------
// Load and start items, and the unused action code, are accepted in the idle
// state and give no vertices. A character item gives six vertices (two
// triangles) and passes through these steps in order: accept, one width-table
// read, a serial divider that splits the atlas slot into column and row, one
// step per slot bit, one multiply and one sum step, then six emits, one vertex
// per cycle when the output is not stalled. The last vertex sits in the output
// register while the next item is taken. Configuration registers take effect
// at once and may be written only while no character is in flight. Width
// table entries are undefined until loaded.
// ---------------------------------------------------------------------------
`include "text_glyph_quad_generator_defines.svh"

module text_glyph_quad_generator #(
  parameter int MAX_GLYPHS = 1024,
  parameter int TEXEL_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic [9:0]         glyph_index,
  input  logic [7:0]         glyph_width,
  input  logic [15:0]        char_code,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic [31:0]        color,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] vertex_x,
  output logic signed [15:0] vertex_y,
  output logic [11:0]        tex_u,
  output logic [11:0]        tex_v,
  output logic [9:0]         surface_index,
  output logic [31:0]        vertex_color,
  output logic               last_vertex
);
  import tgqg_pkg::*;

  cmd_t cmd;

  tgqg_ctrl #(
    .DIV_STEPS($clog2(MAX_GLYPHS))
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  tgqg_datapath #(
    .MAX_GLYPHS(MAX_GLYPHS),
    .TEXEL_BITS(TEXEL_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (action),
    .glyph_index   (glyph_index),
    .glyph_width   (glyph_width),
    .char_code     (char_code),
    .start_x       (start_x),
    .start_y       (start_y),
    .color         (color),
    .vertex_x      (vertex_x),
    .vertex_y      (vertex_y),
    .tex_u         (tex_u),
    .tex_v         (tex_v),
    .surface_index (surface_index),
    .vertex_color  (vertex_color),
    .last_vertex   (last_vertex)
  );

  // a stalled vertex is never overwritten
  `TGQG_ASSERT(a_no_overwrite, !cmd.emit || !out_valid || !out_stall)
  // no new item while a character still has vertices to send
  `TGQG_ASSERT(a_busy_stall, !(out_valid && !last_vertex) || in_stall)
  // vertices of one character follow each other without a gap
  `TGQG_ASSERT_NEXT(a_no_gap, out_valid && !out_stall && !last_vertex, out_valid)

endmodule

// ===== rtl/tgqg_ctrl.sv =====
// ---------------------------------------------------------------------------
// tgqg_ctrl
// sequencer: table read, serial divide, multiply, sum, six vertex emits
// ---------------------------------------------------------------------------
module tgqg_ctrl #(
  parameter int DIV_STEPS = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       action,
  output logic             out_valid,
  input  logic             out_stall,
  output tgqg_pkg::cmd_t   cmd
);
  import tgqg_pkg::*;

  localparam int CW = $clog2(DIV_STEPS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [2:0]    vtx, vtx_next;
  logic          out_valid_next;
  logic          out_free;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    vtx_next   = vtx;
    cmd        = '0;
    cmd.vtx    = vtx;
    in_stall   = (state != ST_IDLE);
    out_free   = !out_valid || !out_stall;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (action == ACT_CHAR) begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CW'(DIV_STEPS - 1)) begin
          state_next = ST_MUL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        vtx_next   = '0;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          if (vtx == LAST_VTX) begin
            state_next = ST_IDLE;
          end else begin
            vtx_next = vtx + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      vtx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      vtx       <= vtx_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/tgqg_datapath.sv =====
// ---------------------------------------------------------------------------
// tgqg_datapath
// config registers, width table, pen state, slot divider and vertex fields
// ---------------------------------------------------------------------------
module tgqg_datapath #(
  parameter int MAX_GLYPHS = 1024,
  parameter int TEXEL_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  tgqg_pkg::cmd_t      cmd,
  input  logic                cfg_write_en,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [1:0]          action,
  input  logic [9:0]          glyph_index,
  input  logic [7:0]          glyph_width,
  input  logic [15:0]         char_code,
  input  logic signed [15:0]  start_x,
  input  logic signed [15:0]  start_y,
  input  logic [31:0]         color,
  output logic signed [15:0]  vertex_x,
  output logic signed [15:0]  vertex_y,
  output logic [11:0]         tex_u,
  output logic [11:0]         tex_v,
  output logic [9:0]          surface_index,
  output logic [31:0]         vertex_color,
  output logic                last_vertex
);
  import tgqg_pkg::*;

  localparam int AW  = $clog2(MAX_GLYPHS);
  localparam int VPW = AW + 9;
  localparam int VSW = AW + 10;
  localparam logic [31:0] TEX_MAX = (32'd1 << TEXEL_BITS) - 32'd1;

  function automatic logic [15:0] sat16(input logic signed [17:0] v);
    logic [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'h7fff;
    end else if (v < -18'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [11:0] sat_tex(input logic [31:0] t);
    logic [31:0] r;
    r = (t > TEX_MAX) ? TEX_MAX : t;
    return r[11:0];
  endfunction

  // configuration
  logic [15:0] ascii_offset;
  logic [7:0]  cell_width;
  logic [7:0]  glyph_height;
  logic [10:0] glyph_count;
  logic [3:0]  surface_shift;
  logic [7:0]  atlas_columns;

  always_ff @(posedge clk) begin
    if (rst) begin
      ascii_offset  <= 16'd0;
      cell_width    <= 8'd8;
      glyph_height  <= 8'd12;
      glyph_count   <= 11'd0;
      surface_shift <= 4'd8;
      atlas_columns <= 8'd16;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_ASCII_OFFSET:  ascii_offset  <= cfg_data;
        REG_CELL_WIDTH:    cell_width    <= cfg_data[7:0];
        REG_GLYPH_HEIGHT:  glyph_height  <= cfg_data[7:0];
        REG_GLYPH_COUNT:   glyph_count   <= cfg_data[10:0];
        REG_SURFACE_SHIFT: surface_shift <= cfg_data[3:0];
        REG_ATLAS_COLUMNS: atlas_columns <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // glyph lookup at accept
  logic [16:0] code_diff;
  logic        glyph_ok;
  logic [15:0] load_idx;
  logic        load_ok;

  always_comb begin
    code_diff = {1'b0, char_code} - {1'b0, ascii_offset};
    glyph_ok  = !code_diff[16] && (code_diff[15:0] < {5'd0, glyph_count}) &&
                ({1'b0, code_diff[15:0]} < 17'(MAX_GLYPHS));
    load_idx  = 16'(glyph_index);
    load_ok   = {1'b0, load_idx} < 17'(MAX_GLYPHS);
  end

  // width table
  logic [7:0]    width_mem [MAX_GLYPHS];
  logic [AW-1:0] g_q;
  logic [7:0]    w_q;

  always_ff @(posedge clk) begin
    if (cmd.accept && action == ACT_LOAD && load_ok) begin
      width_mem[load_idx[AW-1:0]] <= glyph_width;
    end
    w_q <= width_mem[g_q];
  end

  // pen state
  logic [15:0] pen_x, pen_y, line_left;
  logic [15:0] pen_x1, pen_y1, pen_y_nl;
  logic        ok_q;
  logic [31:0] col_q;

  always_comb begin
    pen_y_nl = sat16({{2{pen_y[15]}}, pen_y} + {10'd0, glyph_height});
    pen_x1   = sat16({{2{pen_x[15]}}, pen_x} + {10'd0, w_q});
    pen_y1   = pen_y_nl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x     <= '0;
      pen_y     <= '0;
      line_left <= '0;
    end else if (cmd.accept && action == ACT_START) begin
      pen_x     <= start_x;
      line_left <= start_x;
      pen_y     <= start_y;
    end else if (cmd.accept && action == ACT_CHAR && char_code == NEWLINE_CODE) begin
      pen_x <= line_left;
      pen_y <= pen_y_nl;
    end else if (cmd.sum && ok_q) begin
      pen_x <= pen_x1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && action == ACT_CHAR) begin
      g_q   <= code_diff[AW-1:0];
      ok_q  <= glyph_ok;
      col_q <= color;
    end
  end

  // slot split into column and row, one quotient bit per step
  logic [15:0]   g16, slot16, surf16;
  logic [7:0]    cols;
  logic [8:0]    rem_sh, rem_sub;
  logic [7:0]    div_rem;
  logic [AW-1:0] div_quo;

  always_comb begin
    g16     = 16'(g_q);
    slot16  = g16 & ((16'd1 << surface_shift) - 16'd1);
    surf16  = g16 >> surface_shift;
    cols    = (atlas_columns == 8'd0) ? 8'd1 : atlas_columns;
    rem_sh  = {div_rem, div_quo[AW-1]};
    rem_sub = rem_sh - {1'b0, cols};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_rem <= '0;
      div_quo <= slot16[AW-1:0];
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, cols}) begin
        div_rem <= rem_sub[7:0];
        div_quo <= {div_quo[AW-2:0], 1'b1};
      end else begin
        div_rem <= rem_sh[7:0];
        div_quo <= {div_quo[AW-2:0], 1'b0};
      end
    end
  end

  // texel origin products
  logic [16:0]    u_prod;
  logic [VPW-1:0] v_prod;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      u_prod <= 17'(div_rem) * 17'({1'b0, cell_width} + 9'd2);
      v_prod <= VPW'(div_quo) * VPW'({1'b0, glyph_height} + 9'd2);
    end
  end

  // corner values
  logic [17:0]    u0r, u1r;
  logic [VSW-1:0] v0r, v1r;
  logic [15:0]    x0_q, x1_q, y0_q, y1_q;
  logic [11:0]    u0_q, u1_q, v0_q, v1_q;
  logic [9:0]     surf_q;

  always_comb begin
    u0r = 18'(u_prod) + 18'd1;
    u1r = u0r + 18'(w_q);
    v0r = VSW'(v_prod) + VSW'(1);
    v1r = v0r + VSW'(glyph_height);
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      x0_q <= pen_x;
      y0_q <= pen_y;
      if (ok_q) begin
        x1_q   <= pen_x1;
        y1_q   <= pen_y1;
        u0_q   <= sat_tex(32'(u0r));
        u1_q   <= sat_tex(32'(u1r));
        v0_q   <= sat_tex(32'(v0r));
        v1_q   <= sat_tex(32'(v1r));
        surf_q <= surf16[9:0];
      end else begin
        // blank glyph: all six vertices at the pen
        x1_q   <= pen_x;
        y1_q   <= pen_y;
        u0_q   <= '0;
        u1_q   <= '0;
        v0_q   <= '0;
        v1_q   <= '0;
        surf_q <= '0;
      end
    end
  end

  // output register
  logic is_right, is_bottom;

  always_comb begin
    is_right  = VTX_RIGHT[cmd.vtx];
    is_bottom = VTX_BOTTOM[cmd.vtx];
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      vertex_x      <= is_right ? x1_q : x0_q;
      vertex_y      <= is_bottom ? y1_q : y0_q;
      tex_u         <= is_right ? u1_q : u0_q;
      tex_v         <= is_bottom ? v1_q : v0_q;
      surface_index <= surf_q;
      vertex_color  <= col_q;
      last_vertex   <= (cmd.vtx == LAST_VTX);
    end
  end

endmodule
